@@ src/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Types, codes and fixed constants shared by the pure pursuit steering unit.
// ----------------------------------------------------------------------------
package pps_pkg;

  // request codes
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // configuration register indexes
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_WHEELBASE = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_PWM_CTR   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_PWM_PER30 = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_PWM_UPPER = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_PWM_LOWER = 3'd4;

  localparam logic [11:0] WHEELBASE_RST = 12'd64;
  localparam logic [11:0] PWM_CTR_RST   = 12'd1564;
  localparam logic [9:0]  PWM_PER30_RST = 10'd200;
  localparam logic [11:0] PWM_UPPER_RST = 12'd1763;
  localparam logic [11:0] PWM_LOWER_RST = 12'd1363;

  // CORDIC datapath widths
  localparam int CORW = 52;
  localparam int ZW   = 28;

  localparam logic signed [ZW-1:0]   PI_Q24   = 28'sd52707179;
  localparam logic signed [CORW-1:0] GAIN_Q30 = 52'sd652032874;
  localparam logic signed [17:0]     PI_Q12      = 18'sd12868;
  localparam logic signed [17:0]     HALF_PI_Q12 = 18'sd6434;
  localparam logic signed [17:0]     TWO_PI_Q12  = 18'sd25736;

  // offset = round(|steer * per30| * 600 / (314 * 4096)); 314 * 4096 = 8192 * 157
  localparam logic [35:0] PWM_RND    = 36'd643072;
  localparam logic [35:0] PWM_SCALE  = 36'd600;
  localparam logic [24:0] RECIP_157  = 25'd27356480;  // ceil(2^32 / 157)

  localparam logic signed [ZW-1:0] ATAN_TAB [24] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
    28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
    28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
    28'sd256,      28'sd128,     28'sd64,      28'sd32,
    28'sd16,       28'sd8,       28'sd4,       28'sd2
  };

  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_SCAN  = 18'h00002,
    ST_TGT   = 18'h00004,
    ST_RD    = 18'h00008,
    ST_SQ    = 18'h00010,
    ST_MGO   = 18'h00020,
    ST_MWAIT = 18'h00040,
    ST_ALPHA = 18'h00080,
    ST_SGO   = 18'h00100,
    ST_SWAIT = 18'h00200,
    ST_MUL   = 18'h00400,
    ST_TGO   = 18'h00800,
    ST_TWAIT = 18'h01000,
    ST_STEER = 18'h02000,
    ST_PWM1  = 18'h04000,
    ST_PWM2  = 18'h08000,
    ST_PWM3  = 18'h10000,
    ST_OUT   = 18'h20000
  } state_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic load;
    logic scan_start;
    logic tgt;
    logic sq;
    logic meas_go;
    logic alpha;
    logic sin_go;
    logic mul;
    logic steer_go;
    logic steer;
    logic pwm1;
    logic pwm2;
    logic pwm3;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_done;
    logic busy;
    logic out_free;
  } sts_t;

endpackage

@@ src/pps_ram.sv @@
// ----------------------------------------------------------------------------
// pps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/pps_cordic.sv @@
// ----------------------------------------------------------------------------
// pps_cordic
// Shared iterative CORDIC: vectoring mode for atan2, rotation mode for sine.
// ----------------------------------------------------------------------------
module pps_cordic #(
  parameter int STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              vec,
  input  logic signed [pps_pkg::CORW-1:0]   x_in,
  input  logic signed [pps_pkg::CORW-1:0]   y_in,
  input  logic signed [pps_pkg::ZW-1:0]     z_in,
  output logic                              busy,
  output logic signed [pps_pkg::CORW-1:0]   y_out,
  output logic signed [pps_pkg::ZW-1:0]     z_out
);

  localparam int NW = $clog2(STEPS + 1);

  logic [NW-1:0]                   cnt;
  logic signed [pps_pkg::CORW-1:0] x, y, xs, ys, shx, shy;
  logic signed [pps_pkg::ZW-1:0]   z, ang;
  logic                            zflag;
  logic                            mode_vec;
  logic                            dir_a;
  logic [4:0]                      aidx;

  assign busy = (cnt != NW'(STEPS));

  always_comb begin
    xs    = x_in <<< 16;
    ys    = y_in <<< 16;
    shx   = x >>> cnt;
    shy   = y >>> cnt;
    aidx  = busy ? 5'(cnt) : 5'd0;
    ang   = pps_pkg::ATAN_TAB[aidx];
    dir_a = mode_vec ? (y > 0) : (z < 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= NW'(STEPS);
    end else if (start) begin
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_vec <= vec;
      if (vec) begin
        zflag <= (x_in == '0) && (y_in == '0);
        if (xs < 0) begin
          x <= -xs;
          y <= -ys;
          z <= (ys >= 0) ? pps_pkg::PI_Q24 : -pps_pkg::PI_Q24;
        end else begin
          x <= xs;
          y <= ys;
          z <= '0;
        end
      end else begin
        zflag <= 1'b0;
        x     <= x_in;
        y     <= y_in;
        z     <= z_in;
      end
    end else if (busy) begin
      if (dir_a) begin
        x <= x + shy;
        y <= y - shx;
        z <= z + ang;
      end else begin
        x <= x - shy;
        y <= y + shx;
        z <= z - ang;
      end
    end
  end

  // atan2 of zero by zero reads as zero
  assign z_out = zflag ? '0 : z;
  assign y_out = y;

endmodule

@@ src/pps_ctrl.sv @@
// ----------------------------------------------------------------------------
// pps_ctrl
// Request sequencer: decodes words and steps the datapath through a query.
// ----------------------------------------------------------------------------
module pps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     req_type,
  input  pps_pkg::sts_t  sts,
  output pps_pkg::cmd_t  cmd
);

  pps_pkg::state_t state, state_next;

  assign in_ready = (state == pps_pkg::ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      pps_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (req_type)
            pps_pkg::REQ_CLEAR:  cmd.clear = 1'b1;
            pps_pkg::REQ_APPEND: cmd.append = 1'b1;
            pps_pkg::REQ_QUERY: begin
              cmd.load = 1'b1;
              if (sts.count_zero) begin
                state_next = pps_pkg::ST_OUT;
              end else begin
                cmd.scan_start = 1'b1;
                state_next     = pps_pkg::ST_SCAN;
              end
            end
            default: ;  // unused code: drop the word
          endcase
        end
      end
      pps_pkg::ST_SCAN: begin
        if (sts.scan_done) state_next = pps_pkg::ST_TGT;
      end
      pps_pkg::ST_TGT: begin
        cmd.tgt    = 1'b1;
        state_next = pps_pkg::ST_RD;
      end
      pps_pkg::ST_RD:  state_next = pps_pkg::ST_SQ;
      pps_pkg::ST_SQ: begin
        cmd.sq     = 1'b1;
        state_next = pps_pkg::ST_MGO;
      end
      pps_pkg::ST_MGO: begin
        cmd.meas_go = 1'b1;
        state_next  = pps_pkg::ST_MWAIT;
      end
      pps_pkg::ST_MWAIT: begin
        if (!sts.busy) state_next = pps_pkg::ST_ALPHA;
      end
      pps_pkg::ST_ALPHA: begin
        cmd.alpha  = 1'b1;
        state_next = pps_pkg::ST_SGO;
      end
      pps_pkg::ST_SGO: begin
        cmd.sin_go = 1'b1;
        state_next = pps_pkg::ST_SWAIT;
      end
      pps_pkg::ST_SWAIT: begin
        if (!sts.busy) state_next = pps_pkg::ST_MUL;
      end
      pps_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = pps_pkg::ST_TGO;
      end
      pps_pkg::ST_TGO: begin
        cmd.steer_go = 1'b1;
        state_next   = pps_pkg::ST_TWAIT;
      end
      pps_pkg::ST_TWAIT: begin
        if (!sts.busy) state_next = pps_pkg::ST_STEER;
      end
      pps_pkg::ST_STEER: begin
        cmd.steer  = 1'b1;
        state_next = pps_pkg::ST_PWM1;
      end
      pps_pkg::ST_PWM1: begin
        cmd.pwm1   = 1'b1;
        state_next = pps_pkg::ST_PWM2;
      end
      pps_pkg::ST_PWM2: begin
        cmd.pwm2   = 1'b1;
        state_next = pps_pkg::ST_PWM3;
      end
      pps_pkg::ST_PWM3: begin
        cmd.pwm3   = 1'b1;
        state_next = pps_pkg::ST_OUT;
      end
      pps_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = pps_pkg::ST_IDLE;
        end
      end
      default: state_next = pps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/pps_dp.sv @@
// ----------------------------------------------------------------------------
// pps_dp
// Datapath: path table, nearest point scan, square root, CORDIC, PWM mapping.
// ----------------------------------------------------------------------------
module pps_dp #(
  parameter int PATH_DEPTH   = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pps_pkg::cmd_t                cmd,
  output pps_pkg::sts_t                sts,
  input  logic signed [15:0]           point_x,
  input  logic signed [15:0]           point_y,
  input  logic signed [15:0]           pos_x,
  input  logic signed [15:0]           pos_y,
  input  logic signed [15:0]           heading,
  input  logic [7:0]                   lookahead_offset,
  input  logic                         cfg_wr_en,
  input  logic [pps_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [11:0]                  cfg_wdata,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic signed [15:0]           steer_angle,
  output logic [11:0]                  servo_pwm,
  output logic [7:0]                   goal_index,
  output logic                         no_path
);

  localparam int AW   = $clog2(PATH_DEPTH);
  localparam int CW   = $clog2(PATH_DEPTH + 1);
  localparam int TW   = ((CW > 8) ? CW : 8) + 1;
  localparam int CORW = pps_pkg::CORW;
  localparam int ZW   = pps_pkg::ZW;

  // configuration
  logic [11:0] wheelbase, pwm_center, pwm_upper, pwm_lower;
  logic [9:0]  pwm_per30;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheelbase  <= pps_pkg::WHEELBASE_RST;
      pwm_center <= pps_pkg::PWM_CTR_RST;
      pwm_per30  <= pps_pkg::PWM_PER30_RST;
      pwm_upper  <= pps_pkg::PWM_UPPER_RST;
      pwm_lower  <= pps_pkg::PWM_LOWER_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pps_pkg::CFG_WHEELBASE: wheelbase  <= cfg_wdata;
        pps_pkg::CFG_PWM_CTR:   pwm_center <= cfg_wdata;
        pps_pkg::CFG_PWM_PER30: pwm_per30  <= cfg_wdata[9:0];
        pps_pkg::CFG_PWM_UPPER: pwm_upper  <= cfg_wdata;
        pps_pkg::CFG_PWM_LOWER: pwm_lower  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // path table
  logic [CW-1:0] path_count;
  logic          tab_we;
  logic [AW-1:0] raddr;
  logic [31:0]   rd_data;

  assign tab_we = cmd.append && (path_count < CW'(PATH_DEPTH));

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      path_count <= '0;
    end else if (tab_we) begin
      path_count <= path_count + 1'b1;
    end
  end

  pps_ram #(.WIDTH(32), .DEPTH(PATH_DEPTH)) u_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (path_count[AW-1:0]),
    .wdata ({point_x, point_y}),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // query word
  logic signed [15:0] qx, qy, qh;
  logic [7:0]         qoff;
  logic               qempty;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qx     <= pos_x;
      qy     <= pos_y;
      qh     <= heading;
      qoff   <= lookahead_offset;
      qempty <= (path_count == '0);
    end
  end

  // nearest point scan: read, square, compare
  logic          scan_act, v1, v2, issue;
  logic [CW-1:0] scan_idx, idx1, idx2, close, target_q;
  logic signed [16:0] dxw, dyw, dxr, dyr;
  logic signed [33:0] px2, py2;
  logic [31:0]   sqx, sqy;
  logic [32:0]   dsum, best;
  logic [TW-1:0] tsum;

  assign issue = scan_act && (scan_idx != path_count);
  assign raddr = scan_act ? scan_idx[AW-1:0] : target_q[AW-1:0];

  always_comb begin
    dxw  = 17'($signed(rd_data[31:16])) - 17'(qx);
    dyw  = 17'($signed(rd_data[15:0])) - 17'(qy);
    px2  = dxw * dxw;
    py2  = dyw * dyw;
    dsum = {1'b0, sqx} + {1'b0, sqy};
    tsum = TW'(close) + TW'(qoff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_act <= 1'b0;
      scan_idx <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_act <= 1'b1;
      scan_idx <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
    end else begin
      if (cmd.tgt) scan_act <= 1'b0;
      if (issue) scan_idx <= scan_idx + 1'b1;
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= scan_idx;
    idx2 <= idx1;
    if (v1 || cmd.sq) begin
      sqx <= px2[31:0];
      sqy <= py2[31:0];
    end
    if (cmd.sq) begin
      dxr <= dxw;
      dyr <= dyw;
    end
    // keep the earliest point on ties
    if (v2 && ((idx2 == '0) || (dsum < best))) begin
      best  <= dsum;
      close <= idx2;
    end
    if (cmd.tgt) begin
      if (tsum >= TW'(path_count)) target_q <= path_count - 1'b1;
      else                         target_q <= CW'(tsum);
    end
  end

  // integer square root, one result bit per cycle
  logic [33:0] sq_v, sq_res, sq_bit, sq_trial;
  logic        sqrt_busy;
  logic [16:0] ld;

  assign sqrt_busy = (sq_bit != '0);
  assign sq_trial  = sq_res + sq_bit;
  assign ld        = sq_res[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_bit <= '0;
    end else if (cmd.meas_go) begin
      sq_bit <= 34'd1 << 32;
    end else if (sqrt_busy) begin
      sq_bit <= sq_bit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.meas_go) begin
      sq_v   <= {1'b0, dsum};
      sq_res <= '0;
    end else if (sqrt_busy) begin
      if (sq_v >= sq_trial) begin
        sq_v   <= sq_v - sq_trial;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
    end
  end

  // CORDIC sharing
  logic                   cor_start, cor_busy;
  logic signed [CORW-1:0] cx, cy, cor_y, ld_x, ys2, y_rnd;
  logic signed [ZW-1:0]   cz, cor_z, z_rnd;
  logic signed [15:0]     aq, steer;
  logic signed [17:0]     alpha, a0, a1, a2, a3, a4, a5, a6, s_val;
  logic signed [30:0]     wbs;

  assign cor_start = cmd.meas_go || cmd.sin_go || cmd.steer_go;
  assign ld_x      = CORW'($signed({1'b0, ld, 14'd0}));

  always_comb begin
    if (cmd.meas_go) begin
      cx = CORW'(dxr);
      cy = CORW'(dyr);
    end else if (cmd.sin_go) begin
      cx = pps_pkg::GAIN_Q30;
      cy = '0;
    end else begin
      cx = ld_x;
      cy = ys2;
    end
    cz = cmd.sin_go ? (ZW'(alpha) <<< 12) : '0;
  end

  pps_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .vec   (!cmd.sin_go),
    .x_in  (cx),
    .y_in  (cy),
    .z_in  (cz),
    .busy  (cor_busy),
    .y_out (cor_y),
    .z_out (cor_z)
  );

  always_comb begin
    z_rnd = cor_z + ZW'(2048);
    aq    = z_rnd[ZW-1:12];
    y_rnd = cor_y + CORW'(32768);
    s_val = y_rnd[33:16];
    wbs   = $signed({1'b0, wheelbase}) * s_val;
    // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
    a0 = 18'(aq) - 18'(qh);
    a1 = (a0 > pps_pkg::PI_Q12) ? a0 - pps_pkg::TWO_PI_Q12 : a0;
    a2 = (a1 > pps_pkg::PI_Q12) ? a1 - pps_pkg::TWO_PI_Q12 : a1;
    a3 = (a2 < -pps_pkg::PI_Q12) ? a2 + pps_pkg::TWO_PI_Q12 : a2;
    a4 = (a3 < -pps_pkg::PI_Q12) ? a3 + pps_pkg::TWO_PI_Q12 : a3;
    a5 = (a4 > pps_pkg::HALF_PI_Q12) ? pps_pkg::PI_Q12 - a4 : a4;
    a6 = (a5 < -pps_pkg::HALF_PI_Q12) ? -pps_pkg::PI_Q12 - a5 : a5;
  end

  always_ff @(posedge clk) begin
    if (cmd.alpha) alpha <= a6;
    if (cmd.mul)   ys2   <= CORW'(wbs) <<< 1;
    if (cmd.steer) steer <= aq;
  end

  // PWM mapping
  logic signed [26:0] prod1;
  logic [25:0]        p_abs;
  logic               neg;
  logic [35:0]        mag, nq;
  logic [47:0]        qprod;
  logic [15:0]        qv;
  logic signed [16:0] off;
  logic signed [18:0] pwm_s, pwm_c1, pwm_c2;
  logic [CW+7:0]      tgt_ext;

  always_comb begin
    p_abs   = prod1[26] ? 26'(-prod1) : 26'(prod1);
    nq      = mag + pps_pkg::PWM_RND;
    qprod   = nq[35:13] * pps_pkg::RECIP_157;
    off     = neg ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
    pwm_s   = $signed({7'd0, pwm_center}) + 19'(off);
    pwm_c1  = (pwm_s > $signed({7'd0, pwm_upper})) ? $signed({7'd0, pwm_upper}) : pwm_s;
    pwm_c2  = (pwm_c1 < $signed({7'd0, pwm_lower})) ? $signed({7'd0, pwm_lower}) : pwm_c1;
    tgt_ext = (CW + 8)'(target_q);
  end

  always_ff @(posedge clk) begin
    if (cmd.pwm1) prod1 <= steer * $signed({1'b0, pwm_per30});
    if (cmd.pwm2) begin
      neg <= prod1[26];
      mag <= 36'(p_abs) * pps_pkg::PWM_SCALE;
    end
    if (cmd.pwm3) qv <= qprod[47:32];
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (qempty) begin
        steer_angle <= '0;
        servo_pwm   <= '0;
        goal_index  <= '0;
        no_path     <= 1'b1;
      end else begin
        steer_angle <= steer;
        servo_pwm   <= pwm_c2[11:0];
        goal_index  <= tgt_ext[7:0];
        no_path     <= 1'b0;
      end
    end
  end

  assign sts.count_zero = (path_count == '0);
  assign sts.scan_done  = scan_act && !issue && !v1 && !v2;
  assign sts.busy       = cor_busy || sqrt_busy;
  assign sts.out_free   = !out_valid || out_ready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result word overwritten before it was taken");

  a_target_in_table: assert property (@(posedge clk) disable iff (rst)
    cmd.tgt |=> (target_q < path_count))
    else $error("target index beyond the path table");

  a_iter_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.meas_go || cmd.sin_go || cmd.steer_go) |-> (!cor_busy && !sqrt_busy))
    else $error("iterative unit restarted while busy");

endmodule

@@ src/pure_pursuit_steering_unit.sv @@
// ----------------------------------------------------------------------------
// pure_pursuit_steering_unit
// Pure pursuit path tracker: path point table, steering angle and servo PWM.
// ----------------------------------------------------------------------------
// A clear or append word is taken in the idle state and gives no result. A
// query on a table of N points steps through the nearest point scan, which
// reads one point per cycle from the single read port of the path table, the
// distance square root, which resolves one bit per cycle, and one shared
// CORDIC unit that runs three passes (target bearing atan2, sine, steering
// atan2). A new word is taken once the previous query has moved its result
// into the output register; a query on an empty table skips the scan and
// answers with no_path set.
module pure_pursuit_steering_unit #(
  parameter int PATH_DEPTH   = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 req_type,
  input  logic signed [15:0]         point_x,
  input  logic signed [15:0]         point_y,
  input  logic signed [15:0]         pos_x,
  input  logic signed [15:0]         pos_y,
  input  logic signed [15:0]         heading,
  input  logic [7:0]                 lookahead_offset,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [15:0]         steer_angle,
  output logic [11:0]                servo_pwm,
  output logic [7:0]                 goal_index,
  output logic                       no_path,
  input  logic                       cfg_wr_en,
  input  logic [pps_pkg::CFG_IW-1:0] cfg_index,
  input  logic [11:0]                cfg_wdata
);

  pps_pkg::cmd_t cmd;
  pps_pkg::sts_t sts;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd)
  );

  pps_dp #(
    .PATH_DEPTH   (PATH_DEPTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .point_x          (point_x),
    .point_y          (point_y),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .heading          (heading),
    .lookahead_offset (lookahead_offset),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .steer_angle      (steer_angle),
    .servo_pwm        (servo_pwm),
    .goal_index       (goal_index),
    .no_path          (no_path)
  );

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pure pursuit steering unit: builds path tables,
// runs steering queries against a bit-exact fixed point predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH = 256;
  localparam int STEPS = 16;
  localparam logic [1:0] REQ_NOP = 2'd3;
  localparam logic [pps_pkg::CFG_IW-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] px, py, vx, vy, hd;
    logic [7:0]  la;
  } req_t;

  typedef struct packed {
    logic [15:0] steer;
    logic [11:0] pwm;
    logic [7:0]  tgt;
    logic        nopath;
  } steer_res_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0, cfg_wr_en = 0;
  logic in_ready, out_valid;
  logic [1:0] req_type = 0;
  logic signed [15:0] point_x = 0, point_y = 0, pos_x = 0, pos_y = 0, heading = 0;
  logic [7:0] lookahead_offset = 0;
  logic signed [15:0] steer_angle;
  logic [11:0] servo_pwm, cfg_wdata = 0;
  logic [7:0] goal_index;
  logic no_path;
  logic [pps_pkg::CFG_IW-1:0] cfg_index = 0;

  pure_pursuit_steering_unit uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [11:0] wb_q = pps_pkg::WHEELBASE_RST, ctr_q = pps_pkg::PWM_CTR_RST;
  logic [11:0] up_q = pps_pkg::PWM_UPPER_RST, lo_q = pps_pkg::PWM_LOWER_RST;
  logic [9:0]  per30_q = pps_pkg::PWM_PER30_RST;
  logic signed [15:0] tab_x [DEPTH];
  logic signed [15:0] tab_y [DEPTH];
  int unsigned n_pts = 0;

  req_t pending_reqs[$];
  steer_res_t expected_res[$];
  int errors = 0, n_results = 0, n_queries = 0;
  int send_idle = 0, recv_idle = 0;
  bit hold_off = 0;
  bit in_taken = 0;

  localparam longint ATAN [24] = '{13176795, 7778716, 4110060, 2086331, 1047214,
    524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint atan2_q24(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 65536; y = y * 65536;
    if (x < 0) begin
      z = (y >= 0) ? 52707179 : -52707179;
      x = -x; y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = x >>> i; dy = y >>> i;
      if (y > 0) begin
        x += dy; y -= dx; z += ATAN[i];
      end else begin
        x -= dy; y += dx; z -= ATAN[i];
      end
    end
    return z;
  endfunction

  function automatic longint sin_q14(longint a);
    longint x, y, z, dx, dy;
    x = 652032874; y = 0; z = a * 4096;
    for (int i = 0; i < STEPS; i++) begin
      dx = x >>> i; dy = y >>> i;
      if (z >= 0) begin
        x -= dy; y += dx; z -= ATAN[i];
      end else begin
        x += dy; y -= dx; z += ATAN[i];
      end
    end
    return (y + 32768) >>> 16;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_steering(input req_t r);
    steer_res_t e;
    longint dx, dy, best, d, ld, alpha, s, steer, num, off, pwm;
    int unsigned close, tgt;
    e = '0;
    case (r.req)
      pps_pkg::REQ_CLEAR: n_pts = 0;
      pps_pkg::REQ_APPEND: if (n_pts < DEPTH) begin
        tab_x[n_pts] = r.px; tab_y[n_pts] = r.py; n_pts++;
      end
      pps_pkg::REQ_QUERY: begin
        n_queries++;
        if (n_pts == 0) begin
          e.nopath = 1;
        end else begin
          best = 0; close = 0;
          for (int i = 0; i < n_pts; i++) begin
            dx = tab_x[i] - $signed(r.vx); dy = tab_y[i] - $signed(r.vy);
            d = dx * dx + dy * dy;
            if (i == 0 || d < best) begin
              best = d; close = i;
            end
          end
          tgt = close + r.la;
          if (tgt >= n_pts) tgt = n_pts - 1;
          dx = tab_x[tgt] - $signed(r.vx); dy = tab_y[tgt] - $signed(r.vy);
          ld = root_floor(dx * dx + dy * dy);
          alpha = ((atan2_q24(dy, dx) + 2048) >>> 12) - $signed(r.hd);
          while (alpha > 12868) alpha -= 25736;
          while (alpha < -12868) alpha += 25736;
          if (alpha > 6434) alpha = 12868 - alpha;
          if (alpha < -6434) alpha = -12868 - alpha;
          s = sin_q14(alpha);
          steer = (atan2_q24(2 * longint'(wb_q) * s, ld * 16384) + 2048) >>> 12;
          num = steer * longint'(per30_q) * 600;
          if (num >= 0) off = (num + 643072) / 1286144;
          else off = -((-num + 643072) / 1286144);
          pwm = longint'(ctr_q) + off;
          if (pwm > longint'(up_q)) pwm = up_q;
          if (pwm < longint'(lo_q)) pwm = lo_q;
          e.steer = steer[15:0]; e.pwm = pwm[11:0]; e.tgt = tgt[7:0];
        end
        expected_res = {expected_res, e};
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    errors++;
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_results);
  endtask

  // driver: word accepted at rising edge, predict then, refill at falling edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      in_taken = 1;
      predict_steering(pending_reqs.pop_front());
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_taken) begin
        // hold word
      end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1;
        req_type <= pending_reqs[0].req;
        point_x <= pending_reqs[0].px; point_y <= pending_reqs[0].py;
        pos_x <= pending_reqs[0].vx; pos_y <= pending_reqs[0].vy;
        heading <= pending_reqs[0].hd; lookahead_offset <= pending_reqs[0].la;
      end else in_valid <= 0;
      in_taken = 0;
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  // the driver peeks pending_reqs[0]; the posedge pop keeps it aligned
  always @(posedge clk) begin
    steer_res_t e;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (expected_res.size() == 0) begin
        report("unexpected result", 16'd0, 16'd0);
      end else begin
        e = expected_res.pop_front();
        if (steer_angle !== e.steer) report("steer_angle", steer_angle, e.steer);
        if (servo_pwm !== e.pwm) report("servo_pwm", servo_pwm, e.pwm);
        if (goal_index !== e.tgt) report("goal_index", goal_index, e.tgt);
        if (no_path !== e.nopath) report("no_path", no_path, e.nopath);
      end
    end
  end

  function automatic req_t rand_item(input logic [1:0] req);
    req_t r;
    r.req = req;
    r.px = 16'($urandom); r.py = 16'($urandom); r.vx = 16'($urandom);
    r.vy = 16'($urandom);
    r.hd = 16'($urandom);
    r.la = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(4));
    if ($urandom_range(1)) begin
      // keep points and positions near each other for sensible geometry
      r.px = $signed(r.px) >>> $urandom_range(8);
      r.py = $signed(r.py) >>> $urandom_range(8);
      r.vx = $signed(r.vx) >>> $urandom_range(8);
      r.vy = $signed(r.vy) >>> $urandom_range(8);
    end
    return r;
  endfunction

  task automatic push(input req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
    while (expected_res.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pps_pkg::CFG_IW-1:0] idx, input logic [11:0] val);
    @(negedge clk);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
    case (idx)
      pps_pkg::CFG_WHEELBASE: wb_q = val;
      pps_pkg::CFG_PWM_CTR:   ctr_q = val;
      pps_pkg::CFG_PWM_PER30: per30_q = val[9:0];
      pps_pkg::CFG_PWM_UPPER: up_q = val;
      pps_pkg::CFG_PWM_LOWER: lo_q = val;
      default: ;
    endcase
  endtask

  task automatic random_burst(input int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 3) push(rand_item(pps_pkg::REQ_CLEAR));
      else if (k < 5) push(rand_item(REQ_NOP));
      else if (k < 60) push(rand_item(pps_pkg::REQ_APPEND));
      else push(rand_item(pps_pkg::REQ_QUERY));
    end
  endtask

  initial begin
    req_t r;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 0;

    // directed: empty query, extremes, ties, target on vehicle, ignored code
    r = '0; r.req = pps_pkg::REQ_QUERY; push(r);
    r = '0; r.req = REQ_NOP; push(r);
    r = '0; r.req = pps_pkg::REQ_APPEND; r.px = 16'h7fff; r.py = 16'h8000; push(r);
    r.px = 16'h8000; r.py = 16'h7fff; push(r);
    r.px = 0; r.py = 0; push(r);
    r.px = 0; r.py = 0; push(r);
    r = '0; r.req = pps_pkg::REQ_QUERY; push(r);
    r.la = 8'hff; r.vx = 16'h8000; r.vy = 16'h8000; r.hd = 16'h7fff; push(r);
    r.la = 1; r.vx = 16'h7fff; r.vy = 16'h7fff; r.hd = 16'h8000; push(r);
    r.la = 0; r.vx = 100; r.vy = -50; r.hd = 16'sd12868; push(r);
    r.hd = -16'sd12868; push(r);
    r = '0; r.req = pps_pkg::REQ_CLEAR; push(r);
    r.req = pps_pkg::REQ_QUERY; push(r);
    drain();

    // fill the table beyond its depth so appends get dropped
    for (int i = 0; i < DEPTH + 4; i++) push(rand_item(pps_pkg::REQ_APPEND));
    push(rand_item(pps_pkg::REQ_QUERY));
    push(rand_item(pps_pkg::REQ_QUERY));
    drain();
    push(rand_item(pps_pkg::REQ_CLEAR));

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 47; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 47; end
        default: begin send_idle = 12; recv_idle = 12; end
      endcase
      if (ph == 2) begin
        // long receiver hold-off while queries keep coming
        hold_off = 1;
        for (int i = 0; i < 6; i++) push(rand_item(pps_pkg::REQ_QUERY));
        fork
          begin
            repeat (3000) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      random_burst(130);
      drain();
      case (ph)
        0: begin
          write_reg(pps_pkg::CFG_WHEELBASE, 12'd4095);
          write_reg(pps_pkg::CFG_PWM_PER30, 12'd1023);
          write_reg(pps_pkg::CFG_PWM_UPPER, 12'd4095);
          write_reg(pps_pkg::CFG_PWM_LOWER, 12'd0);
        end
        1: begin
          write_reg(pps_pkg::CFG_WHEELBASE, 12'd1);
          write_reg(pps_pkg::CFG_PWM_PER30, 12'd1);
          write_reg(pps_pkg::CFG_PWM_CTR, 12'd0);
        end
        2: begin
          write_reg(pps_pkg::CFG_PWM_CTR, 12'd4095);
          write_reg(pps_pkg::CFG_PWM_UPPER, 12'd0);
          write_reg(pps_pkg::CFG_PWM_LOWER, 12'd4095);
        end
        3: write_reg(CFG_UNUSED, 12'd123);
        default: begin
          write_reg(pps_pkg::CFG_WHEELBASE, 12'($urandom_range(4095, 1)));
          write_reg(pps_pkg::CFG_PWM_CTR, 12'($urandom_range(4095)));
          write_reg(pps_pkg::CFG_PWM_PER30, 12'($urandom_range(1023, 1)));
          write_reg(pps_pkg::CFG_PWM_UPPER, 12'($urandom_range(4095, 2000)));
          write_reg(pps_pkg::CFG_PWM_LOWER, 12'($urandom_range(1999)));
        end
      endcase
      push(rand_item(pps_pkg::REQ_CLEAR));
    end
    drain();

    $display("covered %0d queries (%0d results), table fill and overflow,", n_queries,
             n_results);
    $display("register extremes, crossed PWM limits and stalls on both sides");
    if (errors == 0) $display("pure_pursuit_steering_unit verification clean");
    else $display("pure_pursuit_steering_unit verification failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("pure_pursuit_steering_unit verification failed");
    $finish;
  end
endmodule
